// ----- design/cffa_pkg.sv -----
// Shared widths, codes and types of the first-fit core allocator.
`timescale 1ns / 1ps
`default_nettype none

package cffa_pkg;

  localparam int unsigned PID_W = 16;
  localparam int unsigned CNT_W = 5;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ALLOC = 3'b010,
    ST_REL   = 3'b100
  } state_e;

  typedef struct packed {
    logic set;
    logic clr;
    logic clear_all;
  } busy_ctl_t;

endpackage

`default_nettype wire

// ----- design/cffa_ifs.sv -----
// Request and result channel interfaces of the first-fit core allocator.
`timescale 1ns / 1ps
`default_nettype none

interface cffa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [cffa_pkg::PID_W-1:0] program_id;
  logic [cffa_pkg::CNT_W-1:0] core_request;

  modport source (output valid, output cmd, output program_id, output core_request,
                  input ready);
  modport sink   (input valid, input cmd, input program_id, input core_request,
                  output ready);
endinterface

interface cffa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cffa_pkg::CNT_W-1:0] core_number;
  logic [cffa_pkg::CNT_W-1:0] free_count;
  logic                       last;

  modport source (output valid, output core_number, output free_count, output last,
                  input ready);
  modport sink   (input valid, input core_number, input free_count, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- design/core_first_fit_allocator_core.sv -----
// Top level of the first-fit core allocator: scan sequencer, owner memory and result register.
//
//   channel  dir  handshake      word
//   req_i    in   valid/ready    cmd, program_id, core_request
//   rsp_o    out  valid/ready    core_number, free_count, last
//   cfg      in   cfg_we_i       cfg_data_i (core count)
//
// One request word is worked on at a time; the next is taken once the last result word has
// been loaded into the output register. An allocate walks the busy bits one core per cycle,
// waiting at a free core while the result register is full, and gives a zero core number for
// each slot left unserved. A release reads the owner memory one core per cycle unless stalled,
// through its registered read port. A stalled result register holds the scan where it stands.
// Reset clears the busy bits at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module core_first_fit_allocator_core #(
  parameter int unsigned MAX_CORES = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cffa_pkg::CNT_W-1:0] cfg_data_i,
  cffa_req_if.sink                        req_i,
  cffa_rsp_if.source                      rsp_o
);

  localparam int unsigned IdxW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int unsigned PtrW = $clog2(MAX_CORES + 1);
  localparam int unsigned CntW = cffa_pkg::CNT_W;
  localparam int unsigned PidW = cffa_pkg::PID_W;

  cffa_pkg::state_e state_q, state_d;

  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] left_q, left_d;
  logic            none_q, none_d;
  logic [PidW-1:0] pid_q, pid_d;
  logic            s1_vld_q, s1_vld_d;
  logic [IdxW-1:0] s1_idx_q, s1_idx_d;
  logic            pend_vld_q, pend_vld_d;
  logic [CntW-1:0] pend_core_q, pend_core_d;
  logic [CntW-1:0] pend_free_q, pend_free_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] free_q, free_d;

  logic            out_vld_q, out_vld_d;
  logic [CntW-1:0] out_core_q, out_core_d;
  logic [CntW-1:0] out_free_q, out_free_d;
  logic            out_last_q, out_last_d;

  cffa_pkg::busy_ctl_t  busy_ctl;
  logic [IdxW-1:0]      busy_idx;
  logic [MAX_CORES-1:0] busy;

  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  logic [PidW-1:0] ram_rdata;

  logic [IdxW-1:0] ptr_idx;
  logic            ptr_in;
  logic            out_room;
  logic            match;
  logic            stall;
  logic            issue;
  logic [CntW-1:0] cfg_clamped;

  assign ptr_idx  = ptr_q[IdxW-1:0];
  assign ptr_in   = 32'(ptr_q) < 32'(count_q);
  assign out_room = !out_vld_q || rsp_o.ready;
  assign match    = s1_vld_q && busy[s1_idx_q] && (ram_rdata == pid_q);
  assign stall    = (state_q == cffa_pkg::ST_REL) && match && pend_vld_q && !out_room;
  assign issue    = ptr_in && !stall;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = CntW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_CORES)) begin
      cfg_clamped = CntW'(MAX_CORES);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  // While a release is stalled the memory re-reads the held entry so its data stays valid.
  assign ram_raddr = stall ? s1_idx_q : ptr_idx;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    none_d      = none_q;
    pid_d       = pid_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_core_d = pend_core_q;
    pend_free_d = pend_free_q;
    count_d     = count_q;
    free_d      = free_q;
    out_vld_d   = out_vld_q && !rsp_o.ready;
    out_core_d  = out_core_q;
    out_free_d  = out_free_q;
    out_last_d  = out_last_q;
    busy_ctl    = '0;
    busy_idx    = ptr_idx;
    ram_we      = 1'b0;
    req_i.ready = 1'b0;

    case (state_q)
      cffa_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          pid_d      = req_i.program_id;
          ptr_d      = '0;
          s1_vld_d   = 1'b0;
          pend_vld_d = 1'b0;
          none_d     = (req_i.core_request == '0);
          if (req_i.core_request == '0) begin
            left_d = CntW'(1);
          end else if (32'(req_i.core_request) > 32'(MAX_CORES)) begin
            left_d = CntW'(MAX_CORES);
          end else begin
            left_d = req_i.core_request;
          end
          if (req_i.cmd == cffa_pkg::CMD_ALLOC) begin
            state_d = cffa_pkg::ST_ALLOC;
          end else begin
            state_d = cffa_pkg::ST_REL;
          end
        end
      end

      cffa_pkg::ST_ALLOC: begin
        if (ptr_in && !none_q && busy[ptr_idx]) begin
          ptr_d = ptr_q + PtrW'(1);
        end else if (out_room) begin
          out_vld_d  = 1'b1;
          out_last_d = (left_q == CntW'(1));
          left_d     = left_q - CntW'(1);
          if (ptr_in && !none_q) begin
            busy_ctl.set = 1'b1;
            ram_we       = 1'b1;
            if (free_q != '0) begin
              free_d = free_q - CntW'(1);
            end
            out_core_d = CntW'(ptr_q) + CntW'(1);
            ptr_d      = ptr_q + PtrW'(1);
          end else begin
            out_core_d = '0;
          end
          out_free_d = free_d;
          if (left_q == CntW'(1)) begin
            state_d = cffa_pkg::ST_IDLE;
          end
        end
      end

      cffa_pkg::ST_REL: begin
        busy_idx = s1_idx_q;
        if (match && !stall) begin
          // The freed core is held back until the next one is found, so that the
          // final word of the release can carry the last marker.
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_core_d = pend_core_q;
            out_free_d = pend_free_q;
            out_last_d = 1'b0;
          end
          busy_ctl.clr = 1'b1;
          if (free_q < count_q) begin
            free_d = free_q + CntW'(1);
          end
          pend_vld_d  = 1'b1;
          pend_core_d = CntW'(s1_idx_q) + CntW'(1);
          pend_free_d = free_d;
        end
        if (!stall) begin
          s1_vld_d = issue;
          s1_idx_d = ptr_idx;
          if (issue) begin
            ptr_d = ptr_q + PtrW'(1);
          end
        end
        if (!s1_vld_q && !ptr_in && out_room) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          out_core_d = pend_vld_q ? pend_core_q : '0;
          out_free_d = pend_vld_q ? pend_free_q : free_q;
          pend_vld_d = 1'b0;
          state_d    = cffa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cffa_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      count_d            = cfg_clamped;
      free_d             = cfg_clamped;
      busy_ctl.clear_all = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cffa_pkg::ST_IDLE;
      ptr_q      <= '0;
      left_q     <= '0;
      none_q     <= 1'b0;
      s1_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      count_q    <= (32'(MAX_CORES) < 32'd16) ? CntW'(MAX_CORES) : CntW'(16);
      free_q     <= (32'(MAX_CORES) < 32'd16) ? CntW'(MAX_CORES) : CntW'(16);
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      left_q     <= left_d;
      none_q     <= none_d;
      s1_vld_q   <= s1_vld_d;
      pend_vld_q <= pend_vld_d;
      count_q    <= count_d;
      free_q     <= free_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q       <= pid_d;
    s1_idx_q    <= s1_idx_d;
    pend_core_q <= pend_core_d;
    pend_free_q <= pend_free_d;
    out_core_q  <= out_core_d;
    out_free_q  <= out_free_d;
    out_last_q  <= out_last_d;
  end

  cffa_busy_map #(
    .NumCores (MAX_CORES)
  ) u_busy_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (busy_ctl),
    .idx_i  (busy_idx),
    .busy_o (busy)
  );

  cffa_ram #(
    .Width (PidW),
    .Depth (MAX_CORES)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_idx),
    .wdata_i (pid_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.core_number = out_core_q;
  assign rsp_o.free_count  = out_free_q;
  assign rsp_o.last        = out_last_q;

  // The free count and the busy bits must always tell the same story.
  a_free_matches_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) - 32'(free_q)) == $countones(busy))
    else $error("free count disagrees with busy bits");

  a_free_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= count_q)
    else $error("free count above core count");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (busy == '0) && (free_q == count_q))
    else $error("core count write did not free all cores");

endmodule

`default_nettype wire

// ----- design/cffa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cffa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/cffa_busy_map.sv -----
// Busy bit per core, cleared at reset and on a core count write.
`timescale 1ns / 1ps
`default_nettype none

module cffa_busy_map #(
  parameter int unsigned NumCores = 16,
  localparam int unsigned IdxW = (NumCores > 1) ? $clog2(NumCores) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cffa_pkg::busy_ctl_t ctl_i,
  input  wire logic [IdxW-1:0]     idx_i,
  output logic [NumCores-1:0]      busy_o
);

  logic [NumCores-1:0] busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (ctl_i.clear_all) begin
      busy_q <= '0;
    end else begin
      if (ctl_i.set) begin
        busy_q[idx_i] <= 1'b1;
      end
      if (ctl_i.clr) begin
        busy_q[idx_i] <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire
